/* rtl/qts_pkg.sv */
// Package: shared types, character codes and parse modes of the quoted token splitter.
`timescale 1ns / 1ps

package qts_pkg;

    localparam logic [7:0] C_NUL    = 8'h00;
    localparam logic [7:0] C_SQUOTE = 8'h27;
    localparam logic [7:0] C_DQUOTE = 8'h22;
    localparam logic [7:0] C_BSLASH = 8'h5C;
    localparam logic [7:0] C_PCT    = 8'h25;
    localparam logic [7:0] DELIM_RST = 8'h2F;

    localparam logic [2:0] MODE_PLAIN  = 3'd0;
    localparam logic [2:0] MODE_SQUOTE = 3'd1;
    localparam logic [2:0] MODE_DQUOTE = 3'd2;
    localparam logic [2:0] MODE_ESCAPE = 3'd3;
    localparam logic [2:0] MODE_PCT    = 3'd4;
    localparam logic [2:0] MODE_PCT2   = 3'd5;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       token_end;
        logic       string_end;
        logic       last;
    } t_result;

    typedef struct packed {
        logic       ok;
        logic [3:0] nib;
    } t_hex;

    function automatic t_hex hex_value(input logic [7:0] c);
        t_hex h;
        h.ok  = 1'b1;
        h.nib = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            h.nib = 4'(c - 8'h30);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            h.nib = 4'(c - 8'h37);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            h.nib = 4'(c - 8'h57);
        end else begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

endpackage

/* rtl/quoted_token_splitter_top.sv */
// Top level: quoted token splitter with percent decoding and a result queue.
// An input byte is registered, then parsed once the queue has room; its results
// are written to the queue, whose head is offered at the output.
// Throughput: one input byte per cycle while the output drains; each byte gives
// 0 to 3 results, sent one per cycle unless i_out_stall, from an 8-entry queue;
// the parse stage waits while the queue has fewer than 3 free entries.
// Reset (synchronous, active low): plain mode, queue empty, delimiter '/'.
`timescale 1ns / 1ps

module quoted_token_splitter_top
    import qts_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_data,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_in_byte,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_byte,
    output logic       o_byte_valid,
    output logic       o_token_end,
    output logic       o_string_end,
    output logic       o_last
);

    localparam int QDEPTH = 8;
    localparam int QAW    = $clog2(QDEPTH);

    logic [7:0]     r_delim;
    logic           r_in_valid;
    logic [7:0]     r_in_byte;
    logic [2:0]     r_mode;
    logic [7:0]     r_held;
    logic [2:0]     n_mode;
    logic [7:0]     n_held;

    t_result        r_queue [QDEPTH];
    logic [QAW-1:0] r_wr_ptr;
    logic [QAW-1:0] r_rd_ptr;
    logic [QAW:0]   r_count;

    t_result        n_res [3];
    logic [1:0]     n_num;

    logic           in_take;
    logic           adv;
    logic           pop;

    logic c_end, c_sq, c_dq, c_bs, c_pct, c_special, c_del, c_plain;
    t_hex h1, h2;

    assign o_cfg_ready = 1'b1;
    assign adv     = r_in_valid && (r_count <= (QAW+1)'(QDEPTH - 3));
    assign o_in_stall = r_in_valid && !adv;
    assign in_take = i_in_valid && !o_in_stall;
    assign pop     = (r_count != '0) && !i_out_stall;

    assign o_out_valid  = (r_count != '0);
    assign o_out_byte   = r_queue[r_rd_ptr].out_byte;
    assign o_byte_valid = r_queue[r_rd_ptr].byte_valid;
    assign o_token_end  = r_queue[r_rd_ptr].token_end;
    assign o_string_end = r_queue[r_rd_ptr].string_end;
    assign o_last       = r_queue[r_rd_ptr].last;

    always_comb begin
        c_end     = (r_in_byte == C_NUL);
        c_sq      = (r_in_byte == C_SQUOTE);
        c_dq      = (r_in_byte == C_DQUOTE);
        c_bs      = (r_in_byte == C_BSLASH);
        c_pct     = (r_in_byte == C_PCT);
        c_special = c_end || c_sq || c_dq || c_bs || c_pct;
        c_del     = !c_special && (r_in_byte == r_delim);
        c_plain   = !c_special && !c_del;
        h1        = hex_value(r_held);
        h2        = hex_value(r_in_byte);
    end

    // Parse one byte: next mode and up to three results.
    always_comb begin
        n_mode = r_mode;
        n_held = r_held;
        n_num  = 2'd0;
        for (int i = 0; i < 3; i++) begin
            n_res[i] = '0;
        end
        if (r_mode == MODE_SQUOTE || r_mode == MODE_DQUOTE) begin
            if (c_end) begin
                n_res[0].token_end  = 1'b1;
                n_res[0].string_end = 1'b1;
                n_num  = 2'd1;
                n_mode = MODE_PLAIN;
            end else if ((r_mode == MODE_SQUOTE) ? c_sq : c_dq) begin
                n_mode = MODE_PLAIN;
            end else begin
                n_res[0].out_byte   = r_in_byte;
                n_res[0].byte_valid = 1'b1;
                n_num = 2'd1;
            end
        end else if (r_mode == MODE_ESCAPE) begin
            if (c_end) begin
                n_res[0].token_end  = 1'b1;
                n_res[0].string_end = 1'b1;
            end else begin
                n_res[0].out_byte   = r_in_byte;
                n_res[0].byte_valid = 1'b1;
            end
            n_num  = 2'd1;
            n_mode = MODE_PLAIN;
        end else if (r_mode == MODE_PCT2 && c_plain) begin
            if (h1.ok && h2.ok) begin
                n_res[0].out_byte   = {h1.nib, h2.nib};
                n_res[0].byte_valid = 1'b1;
                n_num = 2'd1;
            end else begin
                n_res[0].out_byte   = C_PCT;
                n_res[0].byte_valid = 1'b1;
                n_res[1].out_byte   = r_held;
                n_res[1].byte_valid = 1'b1;
                n_res[2].out_byte   = r_in_byte;
                n_res[2].byte_valid = 1'b1;
                n_num = 2'd3;
            end
            n_mode = MODE_PLAIN;
        end else if (r_mode == MODE_PCT && c_plain) begin
            n_held = r_in_byte;
            n_mode = MODE_PCT2;
        end else begin
            // held percent run is released before the new byte
            if (r_mode == MODE_PCT) begin
                n_res[0].out_byte   = C_PCT;
                n_res[0].byte_valid = 1'b1;
                n_num = 2'd1;
            end else if (r_mode == MODE_PCT2) begin
                n_res[0].out_byte   = C_PCT;
                n_res[0].byte_valid = 1'b1;
                n_res[1].out_byte   = r_held;
                n_res[1].byte_valid = 1'b1;
                n_num = 2'd2;
            end
            n_mode = MODE_PLAIN;
            if (c_end) begin
                n_res[n_num].token_end  = 1'b1;
                n_res[n_num].string_end = 1'b1;
                n_num = n_num + 2'd1;
            end else if (c_del) begin
                n_res[n_num].token_end = 1'b1;
                n_num = n_num + 2'd1;
            end else if (c_sq) begin
                n_mode = MODE_SQUOTE;
            end else if (c_dq) begin
                n_mode = MODE_DQUOTE;
            end else if (c_bs) begin
                n_mode = MODE_ESCAPE;
            end else if (c_pct) begin
                n_mode = MODE_PCT;
            end else begin
                n_res[n_num].out_byte   = r_in_byte;
                n_res[n_num].byte_valid = 1'b1;
                n_num = n_num + 2'd1;
            end
        end
        if (n_num != 2'd0) begin
            n_res[n_num - 2'd1].last = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delim    <= DELIM_RST;
            r_in_valid <= 1'b0;
            r_mode     <= MODE_PLAIN;
            r_held     <= 8'd0;
            r_wr_ptr   <= '0;
            r_rd_ptr   <= '0;
            r_count    <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_delim <= i_cfg_data;
            end
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (adv) begin
                r_in_valid <= 1'b0;
            end
            if (adv) begin
                r_mode   <= n_mode;
                r_held   <= n_held;
                r_wr_ptr <= r_wr_ptr + QAW'(n_num);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + QAW'(1);
            end
            r_count <= r_count + (adv ? (QAW+1)'(n_num) : '0) - (QAW+1)'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_in_byte;
        end
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                if (2'(i) < n_num) begin
                    r_queue[r_wr_ptr + QAW'(i)] <= n_res[i];
                end
            end
        end
    end

endmodule

/* tb/tb_quoted_token_splitter_top.sv */
// Testbench for the quoted token splitter: random and directed byte strings, result check.
`timescale 1ns / 1ps

module tb_quoted_token_splitter_top;
    import qts_pkg::*;

    localparam int IDLE_LIMIT = 2000;
    localparam int HOLD_CYCLES = 150;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [7:0] i_cfg_data;
    logic       i_in_valid;
    logic       o_in_stall;
    logic [7:0] i_in_byte;
    logic       o_out_valid;
    logic       i_out_stall;
    logic [7:0] o_out_byte;
    logic       o_byte_valid;
    logic       o_token_end;
    logic       o_string_end;
    logic       o_last;

    quoted_token_splitter_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in_byte    (i_in_byte),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_byte   (o_out_byte),
        .o_byte_valid (o_byte_valid),
        .o_token_end  (o_token_end),
        .o_string_end (o_string_end),
        .o_last       (o_last)
    );

    logic [7:0] bytes_to_send[$];
    t_result    token_results_due[$];

    // splitter state tracked by the testbench
    logic [7:0] split_delim = DELIM_RST;
    logic [2:0] split_mode  = MODE_PLAIN;
    logic [7:0] split_held  = 8'h00;

    logic [7:0] cur_delim = DELIM_RST;
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    int  hold_requests = 0;
    int  hold_served = 0;
    int  hold_left = 0;
    int  err_count = 0;
    int  quiet_cycles = 0;
    bit  in_taken = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic bit is_special(input logic [7:0] c);
        return c == C_NUL || c == C_SQUOTE || c == C_DQUOTE || c == C_BSLASH || c == C_PCT;
    endfunction

    function automatic int hex_nibble(input logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c) - int'("0");
        if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
        if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
        return -1;
    endfunction

    function automatic t_result token_char(input logic [7:0] b);
        t_result r;
        r.out_byte   = b;
        r.byte_valid = 1'b1;
        r.token_end  = 1'b0;
        r.string_end = 1'b0;
        r.last       = 1'b0;
        return r;
    endfunction

    function automatic t_result token_mark(input logic at_string_end);
        t_result r;
        r.out_byte   = 8'h00;
        r.byte_valid = 1'b0;
        r.token_end  = 1'b1;
        r.string_end = at_string_end;
        r.last       = 1'b0;
        return r;
    endfunction

    task automatic split_byte(input logic [7:0] c);
        t_result burst[$];
        logic    spec;
        logic    delim_hit;
        logic    plain;
        int      hi;
        int      lo;
        spec      = is_special(c);
        delim_hit = !spec && c == split_delim;
        plain     = !spec && !delim_hit;
        if (split_mode == MODE_SQUOTE || split_mode == MODE_DQUOTE) begin
            if (c == C_NUL) begin
                burst.push_back(token_mark(1'b1));
                split_mode = MODE_PLAIN;
            end else if ((split_mode == MODE_SQUOTE && c == C_SQUOTE) ||
                         (split_mode == MODE_DQUOTE && c == C_DQUOTE)) begin
                split_mode = MODE_PLAIN;
            end else begin
                burst.push_back(token_char(c));
            end
        end else if (split_mode == MODE_ESCAPE) begin
            if (c == C_NUL) burst.push_back(token_mark(1'b1));
            else burst.push_back(token_char(c));
            split_mode = MODE_PLAIN;
        end else if (split_mode == MODE_PCT2 && plain) begin
            hi = hex_nibble(split_held);
            lo = hex_nibble(c);
            if (hi >= 0 && lo >= 0) begin
                burst.push_back(token_char(8'(hi * 16 + lo)));
            end else begin
                burst.push_back(token_char(C_PCT));
                burst.push_back(token_char(split_held));
                burst.push_back(token_char(c));
            end
            split_mode = MODE_PLAIN;
            split_held = 8'h00;
        end else if (split_mode == MODE_PCT && plain) begin
            split_held = c;
            split_mode = MODE_PCT2;
        end else begin
            // held percent run released by a special byte or delimiter
            if (split_mode == MODE_PCT || split_mode == MODE_PCT2)
                burst.push_back(token_char(C_PCT));
            if (split_mode == MODE_PCT2)
                burst.push_back(token_char(split_held));
            split_mode = MODE_PLAIN;
            split_held = 8'h00;
            if (c == C_NUL) burst.push_back(token_mark(1'b1));
            else if (delim_hit) burst.push_back(token_mark(1'b0));
            else if (c == C_SQUOTE) split_mode = MODE_SQUOTE;
            else if (c == C_DQUOTE) split_mode = MODE_DQUOTE;
            else if (c == C_BSLASH) split_mode = MODE_ESCAPE;
            else if (c == C_PCT) split_mode = MODE_PCT;
            else burst.push_back(token_char(c));
        end
        if (burst.size() != 0) burst[burst.size() - 1].last = 1'b1;
        foreach (burst[k]) token_results_due.push_back(burst[k]);
    endtask

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            err_count++;
        end
    endtask

    // monitor: input and config requests, result check, watchdog
    always @(posedge i_clk) begin : monitor
        t_result want;
        bit      moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                split_delim = i_cfg_data;
                moved = 1'b1;
            end
            if (i_in_valid && !o_in_stall) begin
                split_byte(i_in_byte);
                in_taken = 1'b1;
                moved = 1'b1;
            end
            if (o_out_valid && !i_out_stall) begin
                moved = 1'b1;
                if (token_results_due.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual byte %h flags %b%b%b%b",
                             $time, o_out_byte, o_byte_valid, o_token_end, o_string_end, o_last);
                    err_count++;
                end else begin
                    want = token_results_due.pop_front();
                    check_field("out_byte", want.out_byte, o_out_byte);
                    check_field("byte_valid", 8'(want.byte_valid), 8'(o_byte_valid));
                    check_field("token_end", 8'(want.token_end), 8'(o_token_end));
                    check_field("string_end", 8'(want.string_end), 8'(o_string_end));
                    check_field("last", 8'(want.last), 8'(o_last));
                end
            end
            if (moved) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= IDLE_LIMIT) begin
                    $display("tb: failure");
                    $finish;
                end
            end
        end
    end

    always @(negedge i_clk) begin : driver
        if (i_rst_n && (!i_in_valid || in_taken)) begin
            in_taken = 1'b0;
            if (bytes_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                i_in_valid <= 1'b1;
                i_in_byte  <= bytes_to_send.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin : receiver
        if (hold_left != 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (hold_served != hold_requests) begin
            hold_served++;
            hold_left = HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    function automatic logic [7:0] hex_char(input int v, input bit upper);
        if (v < 10) return 8'("0" + v);
        return upper ? 8'("A" + v - 10) : 8'("a" + v - 10);
    endfunction

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        b = 8'($urandom_range(1, 255));
        if (is_special(b) || b == cur_delim) b = "x";
        return b;
    endfunction

    // one string: tokens of mixed pieces, delimiters between them, zero at the end
    task automatic queue_string();
        int         tokens;
        int         pieces;
        int         r;
        int         n;
        logic [7:0] q;
        logic [7:0] b;
        tokens = $urandom_range(1, 4);
        for (int t = 0; t < tokens; t++) begin
            if (t != 0) bytes_to_send.push_back(cur_delim);
            pieces = $urandom_range(0, 4);
            for (int p = 0; p < pieces; p++) begin
                r = $urandom_range(99);
                if (r < 35) begin
                    bytes_to_send.push_back(plain_byte());
                end else if (r < 50) begin
                    q = $urandom_range(1) ? C_SQUOTE : C_DQUOTE;
                    bytes_to_send.push_back(q);
                    n = $urandom_range(0, 3);
                    for (int k = 0; k < n; k++) begin
                        b = 8'($urandom_range(1, 255));
                        bytes_to_send.push_back(b == q ? 8'("q") : b);
                    end
                    bytes_to_send.push_back(q);
                end else if (r < 60) begin
                    bytes_to_send.push_back(C_BSLASH);
                    bytes_to_send.push_back(8'($urandom_range(1, 255)));
                end else if (r < 80) begin
                    bytes_to_send.push_back(C_PCT);
                    bytes_to_send.push_back(hex_char($urandom_range(15), 1'($urandom_range(1))));
                    bytes_to_send.push_back(hex_char($urandom_range(15), 1'($urandom_range(1))));
                end else if (r < 88) begin
                    bytes_to_send.push_back(C_PCT);
                    bytes_to_send.push_back(8'($urandom_range(1, 255)));
                    bytes_to_send.push_back(8'($urandom_range(1, 255)));
                end else begin
                    bytes_to_send.push_back(8'($urandom_range(0, 255)));
                end
            end
        end
        bytes_to_send.push_back(C_NUL);
    endtask

    task automatic queue_strings(input int count);
        int total;
        total = 0;
        while (total < count) begin
            total -= bytes_to_send.size();
            queue_string();
            total += bytes_to_send.size();
        end
    endtask

    task automatic drain();
        while (bytes_to_send.size() != 0 || i_in_valid || token_results_due.size() != 0)
            @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_delimiter(input logic [7:0] v);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        cur_delim = v;
    endtask

    task automatic run_phase(input logic [7:0] delim, input int s_idle, input int r_idle,
                             input int count, input bit hold);
        write_delimiter(delim);
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        queue_strings(count);
        if (hold) hold_requests++;
        drain();
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = 8'h00;
        i_in_valid  = 1'b0;
        i_in_byte   = 8'h00;
        i_out_stall = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 30;
        recv_idle_pct = 68;
        bytes_to_send = '{8'hFF, "/", "/", C_SQUOTE, "/", C_SQUOTE, C_BSLASH, "/",
                          C_PCT, "4", "1", C_PCT, "0", "0", C_PCT, "g", "z",
                          C_PCT, "a", C_DQUOTE, C_NUL, C_BSLASH, C_NUL, C_PCT, "/", C_NUL};
        queue_strings(50);
        drain();

        run_phase(8'hFF, 30, 68, 60, 1'b0);
        run_phase(8'h01, 68, 30, 60, 1'b0);
        run_phase(C_DQUOTE, 68, 30, 60, 1'b0);
        run_phase(",", 0, 0, 70, 1'b1);

        if (err_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
